### hdl/eaae_pkg.sv
package eaae_pkg;

   // input angle format and CORDIC depth
   localparam int ANGLE_FRAC_BITS = 13;
   localparam int CORDIC_STEPS    = 16;

   // internal fixed point: Q30, wide enough for wrapped angles at the Q3.13 input format
   localparam int INT_FRAC = 30;
   localparam int DW       = 38;
   localparam int MW       = 34;   // multiplier operand width
   localparam int UP_SHIFT = INT_FRAC - ANGLE_FRAC_BITS;
   localparam int WRAP_MAX = 8;    // largest multiple of 2*pi removed by range reduction

   typedef logic signed [DW-1:0] q_type;
   typedef logic signed [MW-1:0] m_type;

   localparam q_type Q_PI      = q_type'(64'sd3373259426);
   localparam q_type Q_HALF_PI = q_type'(64'sd1686629713);
   localparam q_type Q_TWO_PI  = q_type'(64'sd6746518852);
   localparam m_type Q_GAIN    = m_type'(64'sd652032874);
   localparam m_type OUT_SCALE = m_type'(64'sd480631834);
   localparam int    OUT_SHIFT = 46;
   localparam int    OUT_LIMIT = 23040;

   // square root: 64-bit radicand, two bits per step
   localparam int SQ_IN_W = 64;
   localparam int SQ_STEPS = SQ_IN_W / 2;
   localparam int SQ_RT_W = SQ_STEPS;
   localparam int SQ_RM_W = SQ_RT_W + 4;

   // pipeline depths in register stages
   localparam int ROT_LAT = CORDIC_STEPS + 3;
   localparam int VEC_LAT = CORDIC_STEPS + 1;
   localparam int SQ_LAT  = SQ_STEPS + 1;

   function automatic q_type atan_q30(input int i);
      q_type r;
      case (i)
         0:       r = q_type'(843314857);
         1:       r = q_type'(497837829);
         2:       r = q_type'(263043837);
         3:       r = q_type'(133525159);
         4:       r = q_type'(67021687);
         5:       r = q_type'(33543516);
         6:       r = q_type'(16775851);
         7:       r = q_type'(8388437);
         8:       r = q_type'(4194283);
         9:       r = q_type'(2097149);
         10:      r = q_type'(1048576);
         11:      r = q_type'(524288);
         12:      r = q_type'(262144);
         13:      r = q_type'(131072);
         14:      r = q_type'(65536);
         15:      r = q_type'(32768);
         16:      r = q_type'(16384);
         17:      r = q_type'(8192);
         18:      r = q_type'(4096);
         19:      r = q_type'(2048);
         20:      r = q_type'(1024);
         21:      r = q_type'(512);
         22:      r = q_type'(256);
         23:      r = q_type'(128);
         default: r = '0;
      endcase
      return r;
   endfunction

   // Q30 product, floor shift
   function automatic q_type qmul(input m_type a, input m_type b);
      logic signed [2*MW-1:0] p;
      p = a * b;
      return p[INT_FRAC+DW-1:INT_FRAC];
   endfunction

endpackage

### hdl/euler_to_axis_angle_error.sv
// Euler attitude to servo-axis error. Yaw, pitch and roll (radians, signed
// Q3.13) go in on start; one result comes back on rsp_strobe for every
// transfer, carrying the yaw-axis and pitch-axis errors in 1/128 degree,
// clamped to +/-180 degrees. The block is a fixed pipeline: it takes a new
// transfer on every clock (busy is never raised). Results leave in order.
// The pipeline is made of two 16-step rotation CORDIC chains in series
// (19 stages each), the square root, the 16-step vectoring CORDIC
// (17 stages) and the input, multiply and rounding stages. The receiver
// cannot stall the result; rsp_strobe is high for exactly one cycle per
// result.
module euler_to_axis_angle_error (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_yaw_angle,
   input  logic signed [15:0] req_pitch_angle,
   input  logic signed [15:0] req_roll_angle,
   output logic               rsp_strobe,
   output logic signed [15:0] rsp_yaw_axis_error,
   output logic signed [15:0] rsp_pitch_axis_error
);

   localparam int RL  = eaae_pkg::ROT_LAT;
   localparam int DL1 = 2 + eaae_pkg::SQ_LAT;   // m1 -> square root output
   localparam int DL2 = eaae_pkg::VEC_LAT;
   localparam int PW  = 2 * eaae_pkg::MW;

   typedef struct packed {
      eaae_pkg::q_type c;
      eaae_pkg::q_type bx;
      eaae_pkg::q_type by;
      logic            zero;
      eaae_pkg::q_type roll;
   } mid_type;

   typedef struct packed {
      logic            zero;
      eaae_pkg::q_type roll;
   } tail_type;

   // never back-pressures: every stage advances each clock
   assign busy = 1'b0;

   // ---- s0: scale inputs to Q30
   eaae_pkg::q_type yaw_ff, pitch_ff, roll_ff;
   logic            v0_ff;

   always_ff @(posedge clock) begin
      yaw_ff   <= eaae_pkg::q_type'(req_yaw_angle) <<< eaae_pkg::UP_SHIFT;
      pitch_ff <= eaae_pkg::q_type'(req_pitch_angle) <<< eaae_pkg::UP_SHIFT;
      roll_ff  <= eaae_pkg::q_type'(req_roll_angle) <<< eaae_pkg::UP_SHIFT;
      if (reset)
         v0_ff <= 1'b0;
      else
         v0_ff <= start & ~busy;
   end

   // ---- sine/cosine of yaw and pitch
   eaae_pkg::q_type cp, sp, ct, st;
   logic            vy, vp;

   eaae_rot u_rot_yaw (
      .clock (clock), .reset (reset), .i_vld (v0_ff), .i_ang (yaw_ff),
      .i_r0  (eaae_pkg::q_type'(eaae_pkg::Q_GAIN)),
      .o_vld (vy), .o_x (cp), .o_y (sp)
   );

   eaae_rot u_rot_pitch (
      .clock (clock), .reset (reset), .i_vld (v0_ff), .i_ang (pitch_ff),
      .i_r0  (eaae_pkg::q_type'(eaae_pkg::Q_GAIN)),
      .o_vld (vp), .o_x (ct), .o_y (st)
   );

   // roll rides alongside the rotators
   eaae_pkg::q_type rl_ff [0:RL-1];
   always_ff @(posedge clock) begin
      rl_ff[0] <= roll_ff;
      for (int i = 1; i < RL; i++)
         rl_ff[i] <= rl_ff[i-1];
   end

   // ---- m1: products of the trig terms
   mid_type         m1_ff;
   eaae_pkg::q_type st1_ff, d1_ff;
   logic            v1_ff;

   always_ff @(posedge clock) begin
      m1_ff.bx   <= eaae_pkg::qmul(st[eaae_pkg::MW-1:0], cp[eaae_pkg::MW-1:0]);
      m1_ff.by   <= sp;
      m1_ff.c    <= eaae_pkg::qmul(ct[eaae_pkg::MW-1:0], cp[eaae_pkg::MW-1:0]);
      d1_ff      <= eaae_pkg::qmul(ct[eaae_pkg::MW-1:0], sp[eaae_pkg::MW-1:0]);
      st1_ff     <= st;
      m1_ff.zero <= 1'b0;
      m1_ff.roll <= rl_ff[RL-1];
      if (reset)
         v1_ff <= 1'b0;
      else
         v1_ff <= vy & vp;
   end

   // origin flag from registered bx/by, joined into the delay line below
   mid_type m1_src;
   always_comb begin
      m1_src      = m1_ff;
      m1_src.zero = (m1_ff.bx == 0) && (m1_ff.by == 0);
   end

   // ---- m2: squares (signed operands, full width), m3: sum of squares
   logic [PW-1:0]                   sq1_ff, sq2_ff;
   logic [eaae_pkg::SQ_IN_W-1:0]    sum_ff;
   logic                            v2_ff, v3_ff;

   always_ff @(posedge clock) begin
      sq1_ff <= PW'(eaae_pkg::m_type'(st1_ff[eaae_pkg::MW-1:0]))
              * PW'(eaae_pkg::m_type'(st1_ff[eaae_pkg::MW-1:0]));
      sq2_ff <= PW'(eaae_pkg::m_type'(d1_ff[eaae_pkg::MW-1:0]))
              * PW'(eaae_pkg::m_type'(d1_ff[eaae_pkg::MW-1:0]));
      sum_ff <= sq1_ff[eaae_pkg::SQ_IN_W-1:0] + sq2_ff[eaae_pkg::SQ_IN_W-1:0];
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   logic [eaae_pkg::SQ_RT_W-1:0] s_root;
   logic                         vs;

   eaae_sqrt u_sqrt (
      .clock (clock), .reset (reset), .i_vld (v3_ff), .i_v (sum_ff),
      .o_vld (vs), .o_root (s_root)
   );

   mid_type dl1_ff [0:DL1-1];
   always_ff @(posedge clock) begin
      dl1_ff[0] <= m1_src;
      for (int i = 1; i < DL1; i++)
         dl1_ff[i] <= dl1_ff[i-1];
   end

   mid_type mid;
   assign mid = dl1_ff[DL1-1];

   // ---- tilt magnitude and induced roll, in parallel
   eaae_pkg::q_type mag, ind;
   logic            vm, vi;

   eaae_vec u_vec_mag (
      .clock (clock), .reset (reset), .i_vld (vs),
      .i_x   (mid.c), .i_y (eaae_pkg::q_type'(s_root)),
      .o_vld (vm), .o_z (mag)
   );

   eaae_vec u_vec_ind (
      .clock (clock), .reset (reset), .i_vld (vs),
      .i_x   (-mid.bx), .i_y (-mid.by),
      .o_vld (vi), .o_z (ind)
   );

   tail_type dl2_ff [0:DL2-1];
   always_ff @(posedge clock) begin
      dl2_ff[0] <= '{zero: mid.zero, roll: mid.roll};
      for (int i = 1; i < DL2; i++)
         dl2_ff[i] <= dl2_ff[i-1];
   end

   // ---- f: full turn and scaled radius
   eaae_pkg::q_type full_ff, r0_ff;
   logic            vf_ff;

   always_ff @(posedge clock) begin
      full_ff <= (dl2_ff[DL2-1].zero ? '0 : ind) - dl2_ff[DL2-1].roll;
      r0_ff   <= eaae_pkg::qmul(mag[eaae_pkg::MW-1:0], eaae_pkg::Q_GAIN);
      if (reset)
         vf_ff <= 1'b0;
      else
         vf_ff <= vm & vi;
   end

   eaae_pkg::q_type mc, ms;
   logic            vr;

   eaae_rot u_rot_out (
      .clock (clock), .reset (reset), .i_vld (vf_ff), .i_ang (full_ff),
      .i_r0  (r0_ff), .o_vld (vr), .o_x (mc), .o_y (ms)
   );

   // ---- o1: scale to 1/128 degree, o2: round half up and clamp
   logic signed [PW-1:0] py_ff, pp_ff;
   logic                 vo1_ff;

   always_ff @(posedge clock) begin
      py_ff <= eaae_pkg::m_type'(ms[eaae_pkg::MW-1:0]) * eaae_pkg::OUT_SCALE;
      pp_ff <= eaae_pkg::m_type'(mc[eaae_pkg::MW-1:0]) * eaae_pkg::OUT_SCALE;
      if (reset)
         vo1_ff <= 1'b0;
      else
         vo1_ff <= vr;
   end

   function automatic logic signed [15:0] round_clamp(input logic signed [PW-1:0] p);
      logic signed [PW-1:0] r;
      logic signed [PW-1:0] lim;
      r   = (p + (PW'(1) <<< (eaae_pkg::OUT_SHIFT - 1))) >>> eaae_pkg::OUT_SHIFT;
      lim = PW'(eaae_pkg::OUT_LIMIT);
      if (r > lim)
         r = lim;
      if (r < -lim)
         r = -lim;
      return r[15:0];
   endfunction

   always_ff @(posedge clock) begin
      rsp_yaw_axis_error   <= round_clamp(py_ff);
      rsp_pitch_axis_error <= round_clamp(pp_ff);
      if (reset)
         rsp_strobe <= 1'b0;
      else
         rsp_strobe <= vo1_ff;
   end

endmodule

### hdl/eaae_rot.sv
module eaae_rot (
   input  logic              clock,
   input  logic              reset,
   input  logic              i_vld,
   input  eaae_pkg::q_type   i_ang,
   input  eaae_pkg::q_type   i_r0,
   output logic              o_vld,
   output eaae_pkg::q_type   o_x,
   output eaae_pkg::q_type   o_y
);

   localparam int N = eaae_pkg::CORDIC_STEPS;

   eaae_pkg::q_type m_in, m_ff, r1_ff, z_in;
   logic            v1_ff, neg_in;

   eaae_pkg::q_type x_ff [0:N];
   eaae_pkg::q_type y_ff [0:N];
   eaae_pkg::q_type z_ff [0:N];
   logic            neg_ff [0:N];
   logic            v_ff [0:N];

   // remainder by 2*pi, truncating toward zero
   always_comb begin
      eaae_pkg::q_type k2;
      m_in = i_ang;
      for (int k = 1; k <= eaae_pkg::WRAP_MAX; k++) begin
         k2 = eaae_pkg::Q_TWO_PI * eaae_pkg::q_type'(k);
         if (i_ang >= k2)
            m_in = i_ang - k2;
         if (i_ang <= -k2)
            m_in = i_ang + k2;
      end
   end

   always_ff @(posedge clock) begin
      m_ff  <= m_in;
      r1_ff <= i_r0;
      if (reset)
         v1_ff <= 1'b0;
      else
         v1_ff <= i_vld;
   end

   // wrap into (-pi, pi], then fold into [-pi/2, pi/2]
   always_comb begin
      eaae_pkg::q_type w;
      w = m_ff;
      if (m_ff > eaae_pkg::Q_PI)
         w = m_ff - eaae_pkg::Q_TWO_PI;
      else if (m_ff <= -eaae_pkg::Q_PI)
         w = m_ff + eaae_pkg::Q_TWO_PI;
      z_in   = w;
      neg_in = 1'b0;
      if (w > eaae_pkg::Q_HALF_PI) begin
         z_in   = w - eaae_pkg::Q_PI;
         neg_in = 1'b1;
      end else if (w < -eaae_pkg::Q_HALF_PI) begin
         z_in   = w + eaae_pkg::Q_PI;
         neg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      x_ff[0]   <= r1_ff;
      y_ff[0]   <= '0;
      z_ff[0]   <= z_in;
      neg_ff[0] <= neg_in;
      if (reset)
         v_ff[0] <= 1'b0;
      else
         v_ff[0] <= v1_ff;
   end

   for (genvar i = 0; i < N; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (z_ff[i] >= 0) begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - eaae_pkg::atan_q30(i);
         end else begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + eaae_pkg::atan_q30(i);
         end
         neg_ff[i+1] <= neg_ff[i];
         if (reset)
            v_ff[i+1] <= 1'b0;
         else
            v_ff[i+1] <= v_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      o_x <= neg_ff[N] ? -x_ff[N] : x_ff[N];
      o_y <= neg_ff[N] ? -y_ff[N] : y_ff[N];
      if (reset)
         o_vld <= 1'b0;
      else
         o_vld <= v_ff[N];
   end

endmodule

### hdl/eaae_vec.sv
module eaae_vec (
   input  logic              clock,
   input  logic              reset,
   input  logic              i_vld,
   input  eaae_pkg::q_type   i_x,
   input  eaae_pkg::q_type   i_y,
   output logic              o_vld,
   output eaae_pkg::q_type   o_z
);

   localparam int N = eaae_pkg::CORDIC_STEPS;

   eaae_pkg::q_type x_ff [0:N];
   eaae_pkg::q_type y_ff [0:N];
   eaae_pkg::q_type z_ff [0:N];
   logic            v_ff [0:N];

   // quarter-turn pre-rotation for the left half plane
   always_ff @(posedge clock) begin
      if (i_x < 0) begin
         if (i_y >= 0) begin
            x_ff[0] <= i_y;
            y_ff[0] <= -i_x;
            z_ff[0] <= eaae_pkg::Q_HALF_PI;
         end else begin
            x_ff[0] <= -i_y;
            y_ff[0] <= i_x;
            z_ff[0] <= -eaae_pkg::Q_HALF_PI;
         end
      end else begin
         x_ff[0] <= i_x;
         y_ff[0] <= i_y;
         z_ff[0] <= '0;
      end
      if (reset)
         v_ff[0] <= 1'b0;
      else
         v_ff[0] <= i_vld;
   end

   for (genvar i = 0; i < N; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (y_ff[i] > 0) begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + eaae_pkg::atan_q30(i);
         end else begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - eaae_pkg::atan_q30(i);
         end
         if (reset)
            v_ff[i+1] <= 1'b0;
         else
            v_ff[i+1] <= v_ff[i];
      end
   end

   assign o_z   = z_ff[N];
   assign o_vld = v_ff[N];

endmodule

### hdl/eaae_sqrt.sv
module eaae_sqrt (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                i_vld,
   input  logic [eaae_pkg::SQ_IN_W-1:0]        i_v,
   output logic                                o_vld,
   output logic [eaae_pkg::SQ_RT_W-1:0]        o_root
);

   localparam int N  = eaae_pkg::SQ_STEPS;
   localparam int IW = eaae_pkg::SQ_IN_W;
   localparam int RW = eaae_pkg::SQ_RT_W;
   localparam int MW = eaae_pkg::SQ_RM_W;

   logic [IW-1:0] v_ff    [0:N];
   logic [MW-1:0] rem_ff  [0:N];
   logic [RW-1:0] root_ff [0:N];
   logic          vld_ff  [0:N];

   always_ff @(posedge clock) begin
      v_ff[0]    <= i_v;
      rem_ff[0]  <= '0;
      root_ff[0] <= '0;
      if (reset)
         vld_ff[0] <= 1'b0;
      else
         vld_ff[0] <= i_vld;
   end

   // one result bit per stage, digit-by-digit restoring form
   for (genvar k = 0; k < N; k++) begin : g_step
      logic [MW-1:0] rem_n, trial;
      assign rem_n = {rem_ff[k][MW-3:0], v_ff[k][IW-1:IW-2]};
      assign trial = MW'({root_ff[k], 2'b01});
      always_ff @(posedge clock) begin
         v_ff[k+1] <= {v_ff[k][IW-3:0], 2'b00};
         if (rem_n >= trial) begin
            rem_ff[k+1]  <= rem_n - trial;
            root_ff[k+1] <= {root_ff[k][RW-2:0], 1'b1};
         end else begin
            rem_ff[k+1]  <= rem_n;
            root_ff[k+1] <= {root_ff[k][RW-2:0], 1'b0};
         end
         if (reset)
            vld_ff[k+1] <= 1'b0;
         else
            vld_ff[k+1] <= vld_ff[k];
      end
   end

   assign o_root = root_ff[N];
   assign o_vld  = vld_ff[N];

endmodule

### verif/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // Q30 constants of the attitude math
   localparam int            FRAC_IN   = 13;
   localparam int            QF        = 30;
   localparam longint        PI_Q      = 64'sd3373259426;
   localparam longint        HALF_PI_Q = 64'sd1686629713;
   localparam longint        TWO_PI_Q  = 64'sd6746518852;
   localparam longint        GAIN_Q    = 64'sd652032874;
   localparam longint        DEG_SCALE = 64'sd480631834;
   localparam int            DEG_SHIFT = 46;
   localparam longint        SAT_LIM   = 23040;
   localparam int            N_STEPS   = 16;
   localparam int            PIPE_LAT  = 95;
   localparam int            MAX_CYCLES = 400000;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic signed [15:0] req_yaw_angle;
   logic signed [15:0] req_pitch_angle;
   logic signed [15:0] req_roll_angle;
   logic rsp_strobe;
   logic signed [15:0] rsp_yaw_axis_error;
   logic signed [15:0] rsp_pitch_axis_error;

   typedef struct packed {
      logic signed [15:0] yaw_err;
      logic signed [15:0] pitch_err;
   } axis_err_type;

   axis_err_type pending_errs[$];
   int        n_fail;
   int        cycle_cnt;

   euler_to_axis_angle_error DUT (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_yaw_angle       (req_yaw_angle),
      .req_pitch_angle     (req_pitch_angle),
      .req_roll_angle      (req_roll_angle),
      .rsp_strobe          (rsp_strobe),
      .rsp_yaw_axis_error  (rsp_yaw_axis_error),
      .rsp_pitch_axis_error(rsp_pitch_axis_error)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Attitude math in Q30
   // ---------------------------------------------------------------
   // 64-bit arithmetic shift right floors, matching the pipeline
   function automatic longint qmul30(longint a, longint b);
      longint p;
      p = a * b;
      return p >>> QF;
   endfunction

   function automatic longint atan_step(int i);
      longint tbl[24] = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                          16775851, 8388437, 4194283, 2097149, 1048576, 524288,
                          262144, 131072, 65536, 32768, 16384, 8192,
                          4096, 2048, 1024, 512, 256, 128};
      return tbl[i];
   endfunction

   function automatic longint root_floor(longint unsigned v);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv >>= 2;
      end
      return longint'(res);
   endfunction

   // rotation CORDIC: (r0,0) turned by ang, after wrap and fold
   task automatic cordic_turn(input longint ang, input longint r0,
                              output longint xc, output longint ys);
      longint x, y, z, t;
      bit     flip;
      x = r0;
      y = 0;
      flip = 0;
      z = ang % TWO_PI_Q;          // truncating remainder, like C
      if (z > PI_Q) z -= TWO_PI_Q;
      else if (z <= -PI_Q) z += TWO_PI_Q;
      if (z > HALF_PI_Q) begin
         z -= PI_Q;
         flip = 1;
      end else if (z < -HALF_PI_Q) begin
         z += PI_Q;
         flip = 1;
      end
      for (int i = 0; i < N_STEPS; i++) begin
         if (z >= 0) begin
            t = x - (y >>> i);
            y = y + (x >>> i);
            z -= atan_step(i);
         end else begin
            t = x + (y >>> i);
            y = y - (x >>> i);
            z += atan_step(i);
         end
         x = t;
      end
      xc = flip ? -x : x;
      ys = flip ? -y : y;
   endtask

   function automatic longint cordic_atan2(longint y, longint x);
      longint z, t;
      z = 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = y; y = -x; x = t; z = HALF_PI_Q;
         end else begin
            t = -y; y = x; x = t; z = -HALF_PI_Q;
         end
      end
      for (int i = 0; i < N_STEPS; i++) begin
         if (y > 0) begin
            t = x + (y >>> i);
            y = y - (x >>> i);
            z += atan_step(i);
         end else begin
            t = x - (y >>> i);
            y = y + (x >>> i);
            z -= atan_step(i);
         end
         x = t;
      end
      return z;
   endfunction

   function automatic logic signed [15:0] to_deg128(longint v);
      longint r;
      r = (v * DEG_SCALE + (64'sd1 <<< (DEG_SHIFT - 1))) >>> DEG_SHIFT;
      if (r > SAT_LIM) r = SAT_LIM;
      if (r < -SAT_LIM) r = -SAT_LIM;
      return r[15:0];
   endfunction

   task automatic predict_axis_err(input logic signed [15:0] yaw,
                                   input logic signed [15:0] pitch,
                                   input logic signed [15:0] roll,
                                   output axis_err_type res);
      longint yq, pq, rq, cp, sp, ct, st, bx, by, c, d, s, mag, induced, mc, ms;
      yq = longint'(yaw) <<< (QF - FRAC_IN);
      pq = longint'(pitch) <<< (QF - FRAC_IN);
      rq = longint'(roll) <<< (QF - FRAC_IN);
      cordic_turn(yq, GAIN_Q, cp, sp);
      cordic_turn(pq, GAIN_Q, ct, st);
      bx = qmul30(st, cp);
      by = sp;
      c  = qmul30(ct, cp);
      d  = qmul30(ct, sp);
      s  = root_floor(longint'(longint'(st * st) + longint'(d * d)));
      mag = cordic_atan2(s, c);
      // origin: no induced roll; otherwise the half-turned direction
      if (bx == 0 && by == 0) induced = 0;
      else induced = cordic_atan2(-by, -bx);
      cordic_turn(induced - rq, qmul30(mag, GAIN_Q), mc, ms);
      res.yaw_err   = to_deg128(ms);
      res.pitch_err = to_deg128(mc);
   endtask

   // ---------------------------------------------------------------
   // Sender: one transfer per call, random gaps between bursts
   // ---------------------------------------------------------------
   int burst_left;

   task automatic send_attitude(input logic signed [15:0] yaw,
                                input logic signed [15:0] pitch,
                                input logic signed [15:0] roll);
      axis_err_type e;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 3) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
      burst_left--;
      start           <= 1'b1;
      req_yaw_angle   <= yaw;
      req_pitch_angle <= pitch;
      req_roll_angle  <= roll;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_axis_err(yaw, pitch, roll, e);
      pending_errs.push_back(e);
   endtask

   task automatic idle_sender();
      start <= 1'b0;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // Checker: each strobe against the oldest expectation
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_errs.size() == 0) begin
            $error("unexpected result yaw=%0d pitch=%0d",
                   rsp_yaw_axis_error, rsp_pitch_axis_error);
            n_fail++;
         end else begin
            axis_err_type e;
            e = pending_errs.pop_front();
            if (rsp_yaw_axis_error !== e.yaw_err) begin
               $error("yaw_axis_error expected %0d actual %0d",
                      e.yaw_err, rsp_yaw_axis_error);
               n_fail++;
            end
            if (rsp_pitch_axis_error !== e.pitch_err) begin
               $error("pitch_axis_error expected %0d actual %0d",
                      e.pitch_err, rsp_pitch_axis_error);
               n_fail++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > MAX_CYCLES) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic drain_results();
      while (pending_errs.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   // extremes, origin, pure yaw/pitch, pole and wrapped angles
   task automatic test_directed();
      logic signed [15:0] ext[6] = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0001,
                                     16'shFFFF, 16'sd12868};
      send_attitude(0, 0, 0);                // origin, no roll
      send_attitude(0, 0, 16'sd6434);        // origin with roll
      send_attitude(16'sd4096, 0, 0);        // pure yaw
      send_attitude(0, 16'sd4096, 0);        // pure pitch: Y zero, X positive
      send_attitude(0, -16'sd4096, 0);       // pure pitch negative
      send_attitude(16'sd12868, 16'sd12868, 0); // about pi/2 on both
      send_attitude(16'sd25736, 0, 0);       // half a turn of yaw
      send_attitude(0, 16'sd12868, 16'sd3217); // opposite pole
      for (int i = 0; i < 6; i++)
         send_attitude(ext[i], ext[5 - i], ext[(i + 2) % 6]);
      send_attitude(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_attitude(16'sh8000, 16'sh8000, 16'sh8000);
      send_attitude(16'sh5555, 16'shAAAA, 16'sh5555);
      send_attitude(16'shAAAA, 16'sh5555, 16'shAAAA);
   endtask

   // whole Q3.13 range, every bit toggles
   task automatic test_random_full(int n);
      for (int i = 0; i < n; i++)
         send_attitude(16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   // within +-pi/2, where the attitude is physically meaningful
   task automatic test_random_inrange(int n);
      for (int i = 0; i < n; i++)
         send_attitude(16'(int'($urandom_range(0, 25736)) - 12868),
                       16'(int'($urandom_range(0, 25736)) - 12868),
                       16'(int'($urandom_range(0, 25736)) - 12868));
   endtask

   // near the origin and the +pi/2 pitch pole, where the induced roll is touchy
   task automatic test_random_near_axes(int n);
      logic signed [15:0] base;
      for (int i = 0; i < n; i++) begin
         base = ($urandom_range(0, 1) != 0) ? 16'sd12868 : 16'sd0;
         send_attitude(16'(int'($urandom_range(0, 16)) - 8),
                       16'(int'(base) + int'($urandom_range(0, 16)) - 8),
                       16'($urandom));
      end
   endtask

   // hold off until the pipeline has emptied
   task automatic test_drain_pause();
      idle_sender();
      drain_results();
      send_attitude(16'sd100, -16'sd100, 16'sd50);
   endtask

   initial begin
      n_fail          = 0;
      cycle_cnt       = 0;
      burst_left      = 0;
      reset           = 1'b1;
      start           = 1'b0;
      req_yaw_angle   = '0;
      req_pitch_angle = '0;
      req_roll_angle  = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_full(450);
      test_drain_pause();
      test_random_inrange(450);
      test_random_near_axes(200);
      idle_sender();

      drain_results();
      repeat (PIPE_LAT + 10) @(posedge clock);
      if (n_fail == 0 && pending_errs.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

### euler_to_axis_angle_error.f
hdl/eaae_pkg.sv
hdl/eaae_rot.sv
hdl/eaae_vec.sv
hdl/eaae_sqrt.sv
hdl/euler_to_axis_angle_error.sv
verif/tb_top.sv
